@@ rtl/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg
// Shared widths, codes and types for the sorted interval table.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned TIME_W   = 16;
    localparam int unsigned ROOM_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned SLOT_W   = 6;
    localparam int unsigned TOTAL_W  = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CONFLICT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic [ROOM_W-1:0] room;
    } entry_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_REMOVE
    } cmd_t;

    typedef struct packed {
        logic less;
        logic hit;
        logic conflict;
    } cell_flags_t;

    typedef struct packed {
        logic any_conflict;
        logic any_hit;
    } red_flags_t;

endpackage

@@ rtl/sit_if.sv @@
// ----------------------------------------------------------------------------
// sit_if
// Request and response channels of the sorted interval table.
// ----------------------------------------------------------------------------
interface sit_req_if;
    logic                        valid;
    logic                        ready;
    logic [sit_pkg::OP_W-1:0]    operation;
    logic [sit_pkg::TIME_W-1:0]  start_time;
    logic [sit_pkg::TIME_W-1:0]  end_time;
    logic [sit_pkg::ROOM_W-1:0]  room_number;

    modport source (output valid, operation, start_time, end_time, room_number,
                    input ready);
    modport sink   (input valid, operation, start_time, end_time, room_number,
                    output ready);
endinterface

interface sit_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [sit_pkg::STATUS_W-1:0] status;
    logic [sit_pkg::SLOT_W-1:0]   slot_position;
    logic [sit_pkg::TIME_W-1:0]   found_start;
    logic [sit_pkg::TIME_W-1:0]   found_end;
    logic [sit_pkg::ROOM_W-1:0]   found_room;
    logic [sit_pkg::TOTAL_W-1:0]  entry_total;

    modport source (output valid, status, slot_position, found_start, found_end,
                    found_room, entry_total, input ready);
    modport sink   (input valid, status, slot_position, found_start, found_end,
                    found_room, entry_total, output ready);
endinterface

@@ rtl/sit_cell.sv @@
// ----------------------------------------------------------------------------
// sit_cell
// One table slot: holds an entry, compares it with the request key and
// shifts to or from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module sit_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 occupied,
    input  logic                 capture,
    input  sit_pkg::cmd_t        cmd,
    input  sit_pkg::entry_t      key,
    input  logic                 left_less,
    input  sit_pkg::entry_t      left_entry,
    input  sit_pkg::entry_t      right_entry,
    output sit_pkg::entry_t      entry,
    output sit_pkg::cell_flags_t flags
);

    sit_pkg::entry_t      entry_reg;
    sit_pkg::entry_t      entry_next;
    sit_pkg::cell_flags_t flags_reg;
    sit_pkg::cell_flags_t flags_next;

    always_comb
    begin
        flags_next.less     = occupied && (entry_reg.start_time < key.start_time);
        flags_next.hit      = occupied && (entry_reg.start_time == key.start_time);
        flags_next.conflict = occupied &&
            ((entry_reg.start_time == key.start_time) ||
             ((key.start_time > entry_reg.start_time) &&
              (key.start_time < entry_reg.end_time)) ||
             ((key.end_time > entry_reg.start_time) &&
              (key.end_time <= entry_reg.end_time)));
    end

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd)
            sit_pkg::CMD_INSERT:
            begin
                if (!flags_reg.less)
                begin
                    entry_next = left_less ? key : left_entry;
                end
            end
            sit_pkg::CMD_REMOVE:
            begin
                if (!flags_reg.less)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (capture)
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign flags = flags_reg;

endmodule

@@ rtl/sit_reduce.sv @@
// ----------------------------------------------------------------------------
// sit_reduce
// Collects the cell flags into conflict and hit summaries, the insert
// position, the hit position and the hit entry, all registered.
// ----------------------------------------------------------------------------
module sit_reduce #(
    parameter int unsigned DEPTH = sit_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       enable,
    input  logic [DEPTH-1:0]           less_vec,
    input  logic [DEPTH-1:0]           hit_vec,
    input  logic [DEPTH-1:0]           conflict_vec,
    input  sit_pkg::entry_t            entries [DEPTH],
    output sit_pkg::red_flags_t        flags,
    output logic [$clog2(DEPTH)-1:0]   ins_pos,
    output logic [$clog2(DEPTH)-1:0]   hit_pos,
    output sit_pkg::entry_t            hit_entry
);

    localparam int unsigned PW = $clog2(DEPTH);

    logic [DEPTH-1:0]    first_free;
    logic [PW-1:0]       ins_pos_next;
    logic [PW-1:0]       hit_pos_next;
    sit_pkg::entry_t     hit_entry_next;
    sit_pkg::red_flags_t flags_next;

    sit_pkg::red_flags_t flags_reg;
    logic [PW-1:0]       ins_pos_reg;
    logic [PW-1:0]       hit_pos_reg;
    sit_pkg::entry_t     hit_entry_reg;

    // sorted table: less flags form a prefix, first clear one is the slot
    always_comb
    begin
        first_free[0] = ~less_vec[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            first_free[i] = ~less_vec[i] & less_vec[i-1];
        end
    end

    always_comb
    begin
        ins_pos_next   = '0;
        hit_pos_next   = '0;
        hit_entry_next = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first_free[i])
            begin
                ins_pos_next = ins_pos_next | PW'(i);
            end
            if (hit_vec[i])
            begin
                hit_pos_next   = hit_pos_next | PW'(i);
                hit_entry_next = hit_entry_next | entries[i];
            end
        end
        flags_next.any_conflict = |conflict_vec;
        flags_next.any_hit      = |hit_vec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (enable)
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            ins_pos_reg   <= ins_pos_next;
            hit_pos_reg   <= hit_pos_next;
            hit_entry_reg <= hit_entry_next;
        end
    end

    assign flags     = flags_reg;
    assign ins_pos   = ins_pos_reg;
    assign hit_pos   = hit_pos_reg;
    assign hit_entry = hit_entry_reg;

endmodule

@@ rtl/sorted_interval_table.sv @@
// ----------------------------------------------------------------------------
// sorted_interval_table
// Table of intervals kept sorted by start, in a row of cells that compare
// against the request together and shift to their neighbors on update.
//
//   channel  direction  word
//   req      in         operation, start_time, end_time, room_number
//   rsp      out        status, slot_position, found_start, found_end,
//                       found_room, entry_total
//
// Each request passes four steps: accept, cell compare, flag reduction,
// then update and response.
// Reset empties the table at once; no clearing pass.
// A response that is not taken holds the block in its update step;
// a new request is taken while an earlier response still waits.
// ----------------------------------------------------------------------------
module sorted_interval_table #(
    parameter int unsigned DEPTH = sit_pkg::DEPTH_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    sit_req_if.sink  req,
    sit_rsp_if.source rsp
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RED,
        S_APPLY
    } state_t;

    state_t  state_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;

    logic [sit_pkg::OP_W-1:0] op_reg;
    sit_pkg::entry_t          key_reg;

    logic [sit_pkg::STATUS_W-1:0] status_reg;
    logic [sit_pkg::STATUS_W-1:0] status_next;
    logic [PW-1:0]                pos_reg;
    logic [PW-1:0]                pos_next;
    sit_pkg::entry_t              found_reg;
    sit_pkg::entry_t              found_next;
    logic [CW-1:0]                total_reg;

    sit_pkg::cmd_t cmd_next;
    sit_pkg::cmd_t cell_cmd;

    logic req_fire;
    logic go;

    sit_pkg::entry_t      cell_entry [DEPTH];
    sit_pkg::cell_flags_t cell_flags [DEPTH];
    logic [DEPTH-1:0]     less_vec;
    logic [DEPTH-1:0]     hit_vec;
    logic [DEPTH-1:0]     conflict_vec;
    logic [DEPTH-1:0]     occupied;

    sit_pkg::red_flags_t red_flags;
    logic [PW-1:0]       ins_pos;
    logic [PW-1:0]       hit_pos;
    sit_pkg::entry_t     hit_entry;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign go        = (state_reg == S_APPLY) && (!out_valid_reg || rsp.ready);
    assign cell_cmd  = go ? cmd_next : sit_pkg::CMD_HOLD;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            sit_pkg::entry_t left_e;
            sit_pkg::entry_t right_e;
            logic            left_l;

            assign occupied[g] = (count_reg > CW'(g));

            if (g == 0)
            begin : g_first
                assign left_e = key_reg;
                assign left_l = 1'b1;
            end
            else
            begin : g_mid
                assign left_e = cell_entry[g-1];
                assign left_l = cell_flags[g-1].less;
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign right_e = cell_entry[g];
            end
            else
            begin : g_inner
                assign right_e = cell_entry[g+1];
            end

            sit_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .occupied    (occupied[g]),
                .capture     (state_reg == S_CMP),
                .cmd         (cell_cmd),
                .key         (key_reg),
                .left_less   (left_l),
                .left_entry  (left_e),
                .right_entry (right_e),
                .entry       (cell_entry[g]),
                .flags       (cell_flags[g])
            );

            assign less_vec[g]     = cell_flags[g].less;
            assign hit_vec[g]      = cell_flags[g].hit;
            assign conflict_vec[g] = cell_flags[g].conflict;
        end
    endgenerate

    sit_reduce #(
        .DEPTH (DEPTH)
    ) u_reduce (
        .clk          (clk),
        .rst_n        (rst_n),
        .enable       (state_reg == S_RED),
        .less_vec     (less_vec),
        .hit_vec      (hit_vec),
        .conflict_vec (conflict_vec),
        .entries      (cell_entry),
        .flags        (red_flags),
        .ins_pos      (ins_pos),
        .hit_pos      (hit_pos),
        .hit_entry    (hit_entry)
    );

    always_comb
    begin
        status_next = sit_pkg::ST_NOT_FOUND;
        pos_next    = '0;
        found_next  = '0;
        count_next  = count_reg;
        cmd_next    = sit_pkg::CMD_HOLD;
        case (op_reg)
            sit_pkg::OP_INSERT:
            begin
                if (red_flags.any_conflict)
                begin
                    status_next = sit_pkg::ST_CONFLICT;
                end
                else if (count_reg == CW'(DEPTH))
                begin
                    status_next = sit_pkg::ST_FULL;
                end
                else
                begin
                    status_next = sit_pkg::ST_OK;
                    pos_next    = ins_pos;
                    count_next  = count_reg + CW'(1);
                    cmd_next    = sit_pkg::CMD_INSERT;
                end
            end
            sit_pkg::OP_REMOVE:
            begin
                if (red_flags.any_hit)
                begin
                    status_next = sit_pkg::ST_OK;
                    pos_next    = hit_pos;
                    found_next  = hit_entry;
                    count_next  = count_reg - CW'(1);
                    cmd_next    = sit_pkg::CMD_REMOVE;
                end
            end
            sit_pkg::OP_FIND:
            begin
                if (red_flags.any_hit)
                begin
                    status_next = sit_pkg::ST_OK;
                    pos_next    = hit_pos;
                    found_next  = hit_entry;
                end
            end
            default:
            begin
                status_next = sit_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_RED;
                end
                S_RED:
                begin
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    if (go)
                    begin
                        out_valid_reg <= 1'b1;
                        count_reg     <= count_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg             <= req.operation;
            key_reg.start_time <= req.start_time;
            key_reg.end_time   <= req.end_time;
            key_reg.room       <= req.room_number;
        end
        if (go)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            found_reg  <= found_next;
            total_reg  <= count_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.slot_position = sit_pkg::SLOT_W'(pos_reg);
    assign rsp.found_start   = found_reg.start_time;
    assign rsp.found_end     = found_reg.end_time;
    assign rsp.found_room    = found_reg.room;
    assign rsp.entry_total   = sit_pkg::TOTAL_W'(total_reg);

endmodule
